[hdl/qbd_pkg.sv]
// Shared types, codes and constants of the quadtree bitmap decoder.
`default_nettype none

package qbd_pkg;

    // Default frame limits
    localparam int DEF_MAX_WIDTH  = 65536;
    localparam int DEF_MAX_HEIGHT = 65536;

    // Depth of the request queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Header layout
    localparam logic [3:0] HDR_STORE_LEN = 4'd12;
    localparam logic [7:0] MAGIC_0 = 8'h4D;  // 'M'
    localparam logic [7:0] MAGIC_1 = 8'h52;  // 'R'
    localparam logic [7:0] MAGIC_2 = 8'h46;  // 'F'
    localparam logic [7:0] MAGIC_3 = 8'h31;  // '1'

    // Result kinds
    localparam logic [1:0] KIND_LEAF    = 2'd0;
    localparam logic [1:0] KIND_HDR_OK  = 2'd1;
    localparam logic [1:0] KIND_BAD     = 2'd2;
    localparam logic [1:0] KIND_TOO_BIG = 2'd3;

    // Queue request types
    localparam logic ITEM_BODY = 1'b0;
    localparam logic ITEM_HDR  = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_OUTPUT = 2'd1;

    // Color masks for size coloring
    localparam logic [7:0] MASK_RED   = 8'h55;
    localparam logic [7:0] MASK_GREEN = 8'h66;
    localparam logic [7:0] MASK_BLUE  = 8'h78;

    // Deepest tree level (1x1 node)
    localparam logic [2:0] LEVEL_MAX = 3'd6;

    typedef struct packed {
        logic        typ;      // ITEM_BODY or ITEM_HDR
        logic [1:0]  kind;     // header verdict
        logic [7:0]  data;     // body byte
        logic [16:0] fw;
        logic [16:0] fh;
        logic        empty;    // accepted header with zero area
    } q_ctl_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] x_pos;
        logic [15:0] y_pos;
        logic [2:0]  size_log2;
        logic        pixel_bit;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [16:0] frame_width;
        logic [16:0] frame_height;
        logic        image_done;
        logic        last;
    } res_t;

endpackage

`default_nettype wire

[hdl/qbd_front.sv]
// Front end: takes bytes, parses the header, queues header verdicts and body bytes.
`default_nettype none

module qbd_front #(
    parameter int MAX_WIDTH  = qbd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = qbd_pkg::DEF_MAX_HEIGHT,
    parameter int TCW        = 11,
    parameter int TRW        = 11
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [7:0]             in_byte,
    input  wire logic                   pad_output,
    output logic                        q_push,
    input  wire logic                   q_full,
    output qbd_pkg::q_ctl_t             q_ctl,
    output logic [TCW+TRW-1:0]          q_dims
);
    import qbd_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    localparam logic [1:0] FR_HDR  = 2'd0;
    localparam logic [1:0] FR_BODY = 2'd1;
    localparam logic [1:0] FR_DONE = 2'd2;

    logic [1:0]  phase_reg;
    logic [3:0]  idx_reg;
    logic [7:0]  hb_reg [12];

    logic        accept;
    logic [31:0] w32, h32;
    logic        bad, big, ok, empty;
    logic [WW:0] wsum;
    logic [HW:0] hsum;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign w32 = {hb_reg[4], hb_reg[5], hb_reg[6], hb_reg[7]};
    assign h32 = {hb_reg[8], hb_reg[9], hb_reg[10], hb_reg[11]};

    assign bad   = (hb_reg[0] != MAGIC_0) || (hb_reg[1] != MAGIC_1) ||
                   (hb_reg[2] != MAGIC_2) || (hb_reg[3] != MAGIC_3) || (in_byte != 8'd0);
    assign big   = (w32 > 32'(MAX_WIDTH)) || (h32 > 32'(MAX_HEIGHT));
    assign ok    = !bad && !big;
    assign empty = (w32 == 32'd0) || (h32 == 32'd0);

    // Rounded-up sizes; only meaningful when the size check passed
    assign wsum = {1'b0, w32[WW-1:0]} + (WW+1)'(63);
    assign hsum = {1'b0, h32[HW-1:0]} + (HW+1)'(63);

    always_comb
    begin
        q_ctl       = '0;
        q_dims      = '0;
        q_push      = 1'b0;
        unique case (phase_reg)
            FR_HDR:
            begin
                q_ctl.typ = ITEM_HDR;
                q_push    = accept && (idx_reg == HDR_STORE_LEN);
                if (bad)
                    q_ctl.kind = KIND_BAD;
                else if (big)
                    q_ctl.kind = KIND_TOO_BIG;
                else
                begin
                    q_ctl.kind  = KIND_HDR_OK;
                    q_ctl.empty = empty;
                    if (pad_output)
                    begin
                        q_ctl.fw = 17'((wsum >> 6) << 6);
                        q_ctl.fh = 17'((hsum >> 6) << 6);
                    end
                    else
                    begin
                        q_ctl.fw = 17'(w32);
                        q_ctl.fh = 17'(h32);
                    end
                    q_dims = {TRW'(hsum >> 6), TCW'(wsum >> 6)};
                end
            end
            FR_BODY:
            begin
                q_ctl.typ  = ITEM_BODY;
                q_ctl.data = in_byte;
                q_push     = accept;
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= FR_HDR;
            idx_reg   <= 4'd0;
        end
        else if (accept && phase_reg == FR_HDR)
        begin
            if (idx_reg != HDR_STORE_LEN)
                idx_reg <= idx_reg + 4'd1;
            else if (ok && !empty)
                phase_reg <= FR_BODY;
            else
                phase_reg <= FR_DONE;
        end
    end

    // Header store: written before every read, no reset
    always_ff @(posedge clk)
    begin
        if (accept && phase_reg == FR_HDR && idx_reg != HDR_STORE_LEN)
            hb_reg[idx_reg] <= in_byte;
    end

endmodule

`default_nettype wire

[hdl/qbd_fifo.sv]
// Small flip-flop queue carrying requests from the front to the back.
`default_nettype none

module qbd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = qbd_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  head_valid,
    output logic [WIDTH-1:0]      head_data
);
    import qbd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0]  mem_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]       count_reg;

    assign full       = (count_reg == (AW+1)'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

[hdl/qbd_back.sv]
// Back end: walks the quadtree one bit per cycle while results can leave, and builds result items.
`default_nettype none

module qbd_back #(
    parameter int TCW = 11,
    parameter int TRW = 11
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_valid,
    output logic                       q_pop,
    input  wire qbd_pkg::q_ctl_t       q_ctl,
    input  wire logic [TCW+TRW-1:0]    q_dims,
    input  wire logic                  color_mode,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output qbd_pkg::res_t              result
);
    import qbd_pkg::*;

    localparam logic [1:0] BK_IDLE = 2'd0;
    localparam logic [1:0] BK_BODY = 2'd1;
    localparam logic [1:0] BK_DONE = 2'd2;

    logic [1:0]          phase_reg;
    logic                wb_v_reg;
    q_ctl_t              wb_ctl_reg;
    logic [TCW+TRW-1:0]  wb_dims_reg;
    logic [2:0]          bit_idx_reg;
    logic [2:0]          level_reg;
    logic [1:0]          cp_reg [6];
    logic                await_reg;
    logic [TCW-1:0]      tc_reg, ncols_reg;
    logic [TRW-1:0]      sr_reg, nrows_reg;
    logic                pend_v_reg, pend_dec_reg;
    res_t                pend_reg;
    logic                out_v_reg;
    res_t                out_reg;

    logic                is_body, active, bit_v, leaf, emit, step, item_end;
    logic                out_free, move;
    logic [2:0]          lvl_up;
    logic [TCW-1:0]      tc_inc;
    logic [TRW-1:0]      sr_inc;
    logic                col_wrap, row_wrap, done_after;
    logic [5:0]          xoff, yoff;
    logic [31:0]         tc_ext, sr_ext;
    logic [2:0]          lg;
    logic [7:0]          side, z;
    res_t                new_res;

    function automatic logic [7:0] chan(input logic [7:0] zv, input logic [7:0] m);
        return {zv[7], |(zv & m), 6'b0};
    endfunction

    assign is_body  = (wb_ctl_reg.typ == ITEM_BODY);
    assign active   = (phase_reg == BK_BODY);
    assign bit_v    = wb_ctl_reg.data[bit_idx_reg];
    assign leaf     = is_body && active && (await_reg || level_reg >= LEVEL_MAX);
    assign emit     = wb_v_reg && (!is_body || leaf);
    assign out_free = !out_v_reg || res_ready;
    assign step     = wb_v_reg && (!emit || !pend_v_reg || out_free);
    assign move     = pend_v_reg && out_free && (pend_dec_reg || (step && emit));

    // Climb past finished last-children after a leaf
    always_comb
    begin
        lvl_up = level_reg;
        for (int i = 6; i >= 1; i--)
        begin
            if (lvl_up == 3'(i) && cp_reg[i-1] == 2'd3)
                lvl_up = lvl_up - 3'd1;
        end
    end

    assign tc_inc     = tc_reg + 1'b1;
    assign sr_inc     = sr_reg + 1'b1;
    assign col_wrap   = !(tc_inc < ncols_reg);
    assign row_wrap   = !(sr_inc < nrows_reg);
    assign done_after = leaf && (lvl_up == 3'd0) && col_wrap && row_wrap;
    assign item_end   = !is_body || !active || (bit_idx_reg == 3'd0) || done_after;
    assign q_pop      = q_valid && (!wb_v_reg || (step && item_end));

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            xoff[5-i] = (3'(i) < level_reg) && cp_reg[i][0];
            yoff[5-i] = (3'(i) < level_reg) && cp_reg[i][1];
        end
    end

    assign tc_ext = 32'(tc_reg);
    assign sr_ext = 32'(sr_reg);
    assign lg     = LEVEL_MAX - level_reg;
    assign side   = 8'd1 << lg;
    assign z      = {bit_v, side[6:0]};

    always_comb
    begin
        new_res = '0;
        if (!is_body)
        begin
            new_res.kind         = wb_ctl_reg.kind;
            new_res.frame_width  = wb_ctl_reg.fw;
            new_res.frame_height = wb_ctl_reg.fh;
            new_res.image_done   = wb_ctl_reg.empty;
            new_res.last         = 1'b1;
        end
        else
        begin
            new_res.kind      = KIND_LEAF;
            new_res.x_pos     = {tc_ext[9:0], xoff};
            new_res.y_pos     = {sr_ext[9:0], yoff};
            new_res.size_log2 = lg;
            new_res.pixel_bit = bit_v;
            if (color_mode)
            begin
                new_res.red   = chan(z, MASK_RED);
                new_res.green = chan(z, MASK_GREEN);
                new_res.blue  = chan(z, MASK_BLUE);
            end
            else
            begin
                new_res.red   = {8{bit_v}};
                new_res.green = {8{bit_v}};
                new_res.blue  = {8{bit_v}};
            end
            new_res.image_done = done_after;
            new_res.last       = item_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= BK_IDLE;
            wb_v_reg     <= 1'b0;
            bit_idx_reg  <= 3'd0;
            level_reg    <= 3'd0;
            await_reg    <= 1'b0;
            tc_reg       <= '0;
            sr_reg       <= '0;
            ncols_reg    <= '0;
            nrows_reg    <= '0;
            pend_v_reg   <= 1'b0;
            pend_dec_reg <= 1'b0;
            out_v_reg    <= 1'b0;
            for (int j = 0; j < 6; j++)
                cp_reg[j] <= 2'd0;
        end
        else
        begin
            // Working item
            if (q_pop)
            begin
                wb_v_reg    <= 1'b1;
                bit_idx_reg <= 3'd7;
            end
            else if (step && item_end)
                wb_v_reg <= 1'b0;
            else if (step)
                bit_idx_reg <= bit_idx_reg - 3'd1;

            // Tree walk
            if (step && !is_body)
            begin
                if (wb_ctl_reg.kind == KIND_HDR_OK)
                begin
                    {nrows_reg, ncols_reg} <= wb_dims_reg;
                    tc_reg    <= '0;
                    sr_reg    <= '0;
                    level_reg <= 3'd0;
                    await_reg <= 1'b0;
                    for (int j = 0; j < 6; j++)
                        cp_reg[j] <= 2'd0;
                    phase_reg <= wb_ctl_reg.empty ? BK_DONE : BK_BODY;
                end
                else
                    phase_reg <= BK_DONE;
            end
            else if (step && active)
            begin
                if (leaf)
                begin
                    await_reg <= 1'b0;
                    level_reg <= lvl_up;
                    if (lvl_up != 3'd0)
                    begin
                        for (int j = 0; j < 6; j++)
                            if (3'(j + 1) == lvl_up)
                                cp_reg[j] <= cp_reg[j] + 2'd1;
                    end
                    else if (!col_wrap)
                        tc_reg <= tc_inc;
                    else
                    begin
                        tc_reg <= '0;
                        if (row_wrap)
                            phase_reg <= BK_DONE;
                        else
                            sr_reg <= sr_inc;
                    end
                end
                else if (bit_v)
                    await_reg <= 1'b1;
                else
                begin
                    for (int j = 0; j < 6; j++)
                        if (3'(j) == level_reg)
                            cp_reg[j] <= 2'd0;
                    level_reg <= level_reg + 3'd1;
                end
            end

            // Pending result: held until its last flag is known
            if (step && emit)
            begin
                pend_v_reg   <= 1'b1;
                pend_dec_reg <= new_res.last;
            end
            else if (move)
                pend_v_reg <= 1'b0;
            else if (step && item_end && pend_v_reg)
                pend_dec_reg <= 1'b1;

            if (move)
                out_v_reg <= 1'b1;
            else if (res_ready)
                out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            wb_ctl_reg  <= q_ctl;
            wb_dims_reg <= q_dims;
        end
        if (step && emit)
            pend_reg <= new_res;
        else if (step && item_end && pend_v_reg && !pend_dec_reg)
            pend_reg.last <= 1'b1;
        if (move)
            out_reg <= pend_reg;
    end

    assign res_valid = out_v_reg;
    assign result    = out_reg;

endmodule

`default_nettype wire

[hdl/quadtree_bitmap_decoder_top.sv]
// Top level of the quadtree bitmap decoder: front, request queue, back, config registers.
//
// Usage:
//   s_* channel takes the compressed file one byte per request (s_tdata = in_byte).
//   The first 13 bytes are the header; one result reports accept (with frame size),
//   bad format or size too large. Body bytes are then decoded into one leaf-square
//   result per quadtree leaf on the m_* channel, tlast marking the final result
//   caused by a byte. After an error, an empty image or the last tile every byte is
//   swallowed without result until reset.
//   cfg_* channel writes color_mode (index 0) and pad_output (index 1); write only
//   while the block is idle. cfg_ready is always high.
// Throughput: header bytes one per cycle while the request queue has room; body
//   bytes are paced by the back end walking the tree one bit per cycle while results
//   can leave. A 4-deep request queue lets the input run ahead of the walker.
// Path: a header verdict passes the request queue, the working-item register, the
//   holding stage and the output register. A leaf result sits in a holding stage until
//   the next leaf of the same byte or the byte's end fixes its tlast.
// Reset clears all control state; config returns to zero, the header is re-parsed.
// If the receiver stalls, the walker stops at the next leaf once the output register
//   and the holding stage are full; the queue then fills and s_tready drops.
`default_nettype none

module quadtree_bitmap_decoder_top #(
    parameter int MAX_WIDTH  = qbd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = qbd_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Input bytes
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,   // [7:0] in_byte
    // Results
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [15:0] x_pos, [31:16] y_pos, [34:32] size_log2, [35] pixel_bit,
    // [43:36] red, [51:44] green, [59:52] blue, [76:60] frame_width,
    // [93:77] frame_height, [94] image_done, [95] zero
    output logic [95:0]                        m_tdata,
    output logic [1:0]                         m_tuser,   // [1:0] kind
    output logic                               m_tlast,   // last
    // Configuration writes
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [qbd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic                          cfg_data
);
    import qbd_pkg::*;

    // Tile counters sized from the frame limits
    localparam int TCW = $clog2(((MAX_WIDTH + 63) / 64) + 1);
    localparam int TRW = $clog2(((MAX_HEIGHT + 63) / 64) + 1);
    localparam int DW  = TCW + TRW;
    localparam int QW  = $bits(q_ctl_t) + DW;

    logic          color_mode_reg, pad_output_reg;

    logic          q_push, q_full, q_pop, q_valid;
    q_ctl_t        f_ctl, b_ctl;
    logic [DW-1:0] f_dims, b_dims;
    logic [QW-1:0] q_head;
    res_t          res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg <= 1'b0;
            pad_output_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_COLOR_MODE: color_mode_reg <= cfg_data;
                CFG_PAD_OUTPUT: pad_output_reg <= cfg_data;
                default:        ;  // unmapped index: write dropped
            endcase
        end
    end

    qbd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .TCW        (TCW),
        .TRW        (TRW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .pad_output (pad_output_reg),
        .q_push     (q_push),
        .q_full     (q_full),
        .q_ctl      (f_ctl),
        .q_dims     (f_dims)
    );

    qbd_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  ({f_ctl, f_dims}),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    assign {b_ctl, b_dims} = q_head;

    qbd_back #(
        .TCW (TCW),
        .TRW (TRW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_ctl      (b_ctl),
        .q_dims     (b_dims),
        .color_mode (color_mode_reg),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .result     (res)
    );

    assign m_tdata = {1'b0, res.image_done, res.frame_height, res.frame_width,
                      res.blue, res.green, res.red, res.pixel_bit, res.size_log2,
                      res.y_pos, res.x_pos};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

    // Header verdicts are the only result of their byte
    a_hdr_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && res.kind != KIND_LEAF) |-> m_tlast)
        else $error("header result without last");

    // Leaf results carry no frame size
    a_leaf_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && res.kind == KIND_LEAF) |->
            (res.frame_width == 17'd0 && res.frame_height == 17'd0))
        else $error("frame size on leaf result");

    // Leaf squares sit on a grid of their own size
    a_leaf_align: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && res.kind == KIND_LEAF) |->
            (res.size_log2 <= LEVEL_MAX &&
             (res.x_pos & ((16'd1 << res.size_log2) - 16'd1)) == 16'd0 &&
             (res.y_pos & ((16'd1 << res.size_log2) - 16'd1)) == 16'd0))
        else $error("misaligned leaf square");

    // The queue is written while full only in a cycle that also pops it
    a_q_push: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && q_full) |-> q_pop)
        else $error("request queue overflow");

endmodule

`default_nettype wire

[verif/tb_quadtree_bitmap_decoder_top.sv]
// Self-checking testbench for the quadtree bitmap decoder: file bytes in, checked results out.

module tb_quadtree_bitmap_decoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    import qbd_pkg::*;

    // Cycles to wait once nothing is pending: time for 4 queued body bytes, one byte in
    // the walker and the output stages, with margin.
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_ROUNDS = 9;
    localparam int ROUND_BYTES   = 28;
    localparam int REPORT_LIMIT  = 10;

    typedef enum logic [1:0] {DEC_HEADER, DEC_BODY, DEC_DONE} dec_phase_t;

    // ------------------------------------------------------------------
    // DUT connections; every input starts at a known value
    // ------------------------------------------------------------------
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = 8'h00;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [95:0]          m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_COLOR_MODE;
    logic                 cfg_data  = 1'b0;

    quadtree_bitmap_decoder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5;
        clk = 1'b1;
        #5;
        clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder state mirrored by the testbench
    // ------------------------------------------------------------------
    logic [7:0]  hdr_store [12];
    int          hdr_count;
    dec_phase_t  dec_phase;
    logic [31:0] img_w;
    logic [31:0] img_h;
    int          tile_col;
    int          strip_row;
    int          level;          // 0 = 64x64 root, 6 = single pixel
    logic [1:0]  path [6];       // child index taken at each level, TL/TR/BL/BR
    logic        want_value;     // leaf flag seen, value bit comes next
    logic        color_mode_q;
    logic        pad_output_q;

    res_t        decoded_q [$];  // results still owed by the DUT, oldest first
    logic [7:0]  file_bytes [$]; // file bytes not yet offered on s_*
    int          src_idle_pct;
    int          sink_idle_pct;
    int          bad_results;

    // Step past a finished leaf. Returns 1 once the last tile of the last strip closes.
    function automatic logic next_node();
        while (level > 0 && path[level-1] == 2'd3)
            level--;
        if (level > 0)
        begin
            path[level-1]++;
            return 1'b0;
        end
        tile_col++;
        if (tile_col < int'((img_w + 32'd63) >> 6))
            return 1'b0;
        tile_col = 0;
        strip_row++;
        if (strip_row < int'((img_h + 32'd63) >> 6))
            return 1'b0;
        dec_phase = DEC_DONE;
        return 1'b1;
    endfunction

    function automatic res_t make_leaf(logic v);
        res_t        r;
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  z;
        int          lg;
        int          i;
        r  = '0;
        x  = 16'(tile_col * 64);
        y  = 16'(strip_row * 64);
        for (i = 0; i < level; i++)
        begin
            if (path[i][0])
                x += 16'(32 >> i);
            if (path[i][1])
                y += 16'(32 >> i);
        end
        lg = 6 - level;
        // colour key: value in bit 7, side in the low bits
        z  = {v, 7'b0} | 8'(1 << lg);
        if (color_mode_q)
        begin
            r.red   = (z & 8'h80) | (((z & MASK_RED)   != 8'h00) ? 8'h40 : 8'h00);
            r.green = (z & 8'h80) | (((z & MASK_GREEN) != 8'h00) ? 8'h40 : 8'h00);
            r.blue  = (z & 8'h80) | (((z & MASK_BLUE)  != 8'h00) ? 8'h40 : 8'h00);
        end
        else
        begin
            r.red   = {8{v}};
            r.green = {8{v}};
            r.blue  = {8{v}};
        end
        r.kind       = KIND_LEAF;
        r.x_pos      = x;
        r.y_pos      = y;
        r.size_log2  = 3'(lg);
        r.pixel_bit  = v;
        r.image_done = next_node();   // position is taken before the walk moves on
        return r;
    endfunction

    // Work out what one accepted file byte must produce and queue it.
    function automatic void decode_byte(logic [7:0] b);
        res_t        r;
        res_t        held;
        logic        have_held;
        logic [31:0] w;
        logic [31:0] h;
        logic        empty;
        int          k;
        case (dec_phase)
            DEC_HEADER:
            begin
                if (hdr_count < 12)
                begin
                    hdr_store[hdr_count] = b;
                    hdr_count++;
                end
                else
                begin
                    // 13th byte: verdict, then nothing more unless the image has area
                    dec_phase = DEC_DONE;
                    r = '0;
                    w = {hdr_store[4], hdr_store[5], hdr_store[6], hdr_store[7]};
                    h = {hdr_store[8], hdr_store[9], hdr_store[10], hdr_store[11]};
                    if (hdr_store[0] != MAGIC_0 || hdr_store[1] != MAGIC_1 ||
                        hdr_store[2] != MAGIC_2 || hdr_store[3] != MAGIC_3 || b != 8'h00)
                        r.kind = KIND_BAD;
                    else if (w > 32'(DEF_MAX_WIDTH) || h > 32'(DEF_MAX_HEIGHT))
                        r.kind = KIND_TOO_BIG;
                    else
                    begin
                        empty      = (w == 0 || h == 0);
                        img_w      = w;
                        img_h      = h;
                        tile_col   = 0;
                        strip_row  = 0;
                        level      = 0;
                        want_value = 1'b0;
                        foreach (path[i])
                            path[i] = 2'd0;
                        if (!empty)
                            dec_phase = DEC_BODY;
                        r.kind         = KIND_HDR_OK;
                        r.frame_width  = pad_output_q ? 17'((w + 32'd63) & ~32'd63) : 17'(w);
                        r.frame_height = pad_output_q ? 17'((h + 32'd63) & ~32'd63) : 17'(h);
                        r.image_done   = empty;
                    end
                    r.last = 1'b1;
                    decoded_q.push_back(r);
                end
            end
            DEC_BODY:
            begin
                // hold each leaf back one step so the byte's final one gets last
                have_held = 1'b0;
                held      = '0;
                for (k = 7; k >= 0; k--)
                begin
                    if (dec_phase == DEC_BODY)
                    begin
                        if (want_value || level >= int'(LEVEL_MAX))
                        begin
                            want_value = 1'b0;
                            r = make_leaf(b[k]);
                            if (have_held)
                                decoded_q.push_back(held);
                            held      = r;
                            have_held = 1'b1;
                        end
                        else if (b[k])
                            want_value = 1'b1;
                        else
                        begin
                            path[level] = 2'd0;
                            level++;
                        end
                    end
                end
                if (have_held)
                begin
                    held.last = 1'b1;
                    decoded_q.push_back(held);
                end
            end
            default: ;   // after an error or a finished image every byte is dropped
        endcase
    endfunction

    function automatic void compare_result(logic [1:0] tuser, logic [95:0] tdata,
                                           logic tlast);
        res_t  got;
        res_t  want;
        string diffs;
        got.kind         = tuser;
        got.x_pos        = tdata[15:0];
        got.y_pos        = tdata[31:16];
        got.size_log2    = tdata[34:32];
        got.pixel_bit    = tdata[35];
        got.red          = tdata[43:36];
        got.green        = tdata[51:44];
        got.blue         = tdata[59:52];
        got.frame_width  = tdata[76:60];
        got.frame_height = tdata[93:77];
        got.image_done   = tdata[94];
        got.last         = tlast;
        if (decoded_q.size() == 0)
        begin
            bad_results++;
            if (bad_results <= REPORT_LIMIT)
                $display("unexpected result %h with nothing pending", got);
            return;
        end
        want  = decoded_q.pop_front();
        diffs = "";
        if (got.kind != want.kind)                 diffs = {diffs, " kind"};
        if (got.x_pos != want.x_pos)               diffs = {diffs, " x_pos"};
        if (got.y_pos != want.y_pos)               diffs = {diffs, " y_pos"};
        if (got.size_log2 != want.size_log2)       diffs = {diffs, " size_log2"};
        if (got.pixel_bit != want.pixel_bit)       diffs = {diffs, " pixel_bit"};
        if (got.red != want.red)                   diffs = {diffs, " red"};
        if (got.green != want.green)               diffs = {diffs, " green"};
        if (got.blue != want.blue)                 diffs = {diffs, " blue"};
        if (got.frame_width != want.frame_width)   diffs = {diffs, " frame_width"};
        if (got.frame_height != want.frame_height) diffs = {diffs, " frame_height"};
        if (got.image_done != want.image_done)     diffs = {diffs, " image_done"};
        if (got.last != want.last)                 diffs = {diffs, " last"};
        if (diffs != "")
        begin
            bad_results++;
            if (bad_results <= REPORT_LIMIT)
                $display("mismatch in%s: expected %h, got %h", diffs, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Byte driver: offers queued bytes, decodes each one on acceptance
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
        end
        else
        begin
            if (s_tvalid && s_tready)
                decode_byte(s_tdata);
            if (!s_tvalid || s_tready)
            begin
                if (file_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= file_bytes.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: random back-pressure, checks every accepted result
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                compare_result(m_tuser, m_tdata, m_tlast);
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Register write; only called with the decoder idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_COLOR_MODE)
            color_mode_q = val;
        else if (idx == CFG_PAD_OUTPUT)
            pad_output_q = val;
        cfg_valid <= 1'b0;
    endtask

    // Wait until every byte is taken and every owed result has come, then let the
    // walker finish bytes that owe nothing. Polling on the falling edge keeps it
    // clear of the driver's queue pops.
    task automatic drain();
        @(negedge clk);
        while (file_bytes.size() != 0 || s_tvalid)
            @(negedge clk);
        while (decoded_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Body byte mix: plain random trees, leaf-heavy bytes so the walk crosses many
    // tiles and strips, whole-tile runs, and split-heavy bytes for pixel-level leaves.
    function automatic logic [7:0] random_body_byte();
        int sel;
        sel = $urandom_range(99);
        if (sel < 45)
            return 8'($urandom);
        else if (sel < 80)
            return 8'($urandom | $urandom);
        else if (sel < 92)
            return 8'hFF;
        else
            return 8'($urandom & $urandom);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus: one image per run, since only reset clears the decoder
    // ------------------------------------------------------------------
    initial
    begin
        logic [7:0] header_run [13];
        logic [7:0] mono_run [11];
        logic [7:0] color_run [6];
        int         round;

        hdr_count    = 0;
        dec_phase    = DEC_HEADER;
        img_w        = '0;
        img_h        = '0;
        tile_col     = 0;
        strip_row    = 0;
        level        = 0;
        want_value   = 1'b0;
        foreach (path[i])
            path[i] = 2'd0;
        foreach (hdr_store[i])
            hdr_store[i] = 8'h00;
        color_mode_q  = 1'b0;
        pad_output_q  = 1'b0;
        bad_results   = 0;
        src_idle_pct  = 14;
        sink_idle_pct = 80;

        // 2000 x 200: 32 tile columns (last one partial) by 4 strips
        header_run = '{MAGIC_0, MAGIC_1, MAGIC_2, MAGIC_3,
                       8'h00, 8'h00, 8'h07, 8'hD0,
                       8'h00, 8'h00, 8'h00, 8'hC8, 8'h00};
        // all-zero byte dives to pixel level; all-ones closes pixels, then bigger leaves
        mono_run   = '{8'h00, 8'hFF, 8'h00, 8'h55, 8'hAA, 8'h80,
                       8'h7F, 8'hC3, 8'h3C, 8'h0F, 8'hF0};
        color_run  = '{8'hFF, 8'hB7, 8'h00, 8'hFF, 8'hE9, 8'h6D};

        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;

        // padding is sampled by the header verdict: 2048 x 256 expected
        write_reg(CFG_COLOR_MODE, 1'b0);
        write_reg(CFG_PAD_OUTPUT, 1'b1);
        foreach (header_run[i])
            file_bytes.push_back(header_run[i]);
        drain();

        foreach (mono_run[i])
            file_bytes.push_back(mono_run[i]);
        drain();

        write_reg(CFG_COLOR_MODE, 1'b1);
        foreach (color_run[i])
            file_bytes.push_back(color_run[i]);
        drain();

        // random rounds, cycling through all register settings; idling swaps
        // sides after three rounds and stops after six
        for (round = 0; round < RANDOM_ROUNDS && dec_phase != DEC_DONE; round++)
        begin
            if (round == 3)
            begin
                src_idle_pct  = 80;
                sink_idle_pct = 14;
            end
            if (round == 6)
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            write_reg(CFG_COLOR_MODE, round[0]);
            write_reg(CFG_PAD_OUTPUT, round[1]);
            repeat (ROUND_BYTES)
                file_bytes.push_back(random_body_byte());
            drain();
        end

        // whole-tile leaves until the last tile of the last strip is done
        while (dec_phase != DEC_DONE)
        begin
            repeat (8)
                file_bytes.push_back(8'hFF);
            drain();
        end

        // bytes after the finished image must be swallowed without results
        repeat (6)
            file_bytes.push_back(8'($urandom));
        drain();

        if (bad_results == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
